// ===== design/nsir_pkg.sv =====
// Types, timing constants and match helper for the NEC/Samsung IR frame decoder.
package nsir_pkg;

	localparam int DUR_W  = 15;
	localparam int TOL_W  = 8;
	localparam int CODE_W = 32;
	localparam int LEN_W  = 8;

	localparam logic [DUR_W-1:0] NEC_HDR_MARK  = 15'd9000;
	localparam logic [DUR_W-1:0] NEC_HDR_SPACE = 15'd4500;
	localparam logic [DUR_W-1:0] SAM_HDR_MARK  = 15'd4500;
	localparam logic [DUR_W-1:0] SAM_HDR_SPACE = 15'd4500;
	localparam logic [DUR_W-1:0] BIT_MARK      = 15'd560;
	localparam logic [DUR_W-1:0] ONE_SPACE     = 15'd1690;
	localparam logic [DUR_W-1:0] ZERO_SPACE    = 15'd560;
	localparam logic [DUR_W-1:0] FOOTER_MARK   = 15'd560;

	localparam logic [TOL_W-1:0] TOL_RESET = 8'd200;
	localparam logic [LEN_W-1:0] LEN_MAX   = 8'd255;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [TOL_W-1:0]  tol_t;

	typedef enum logic [1:0] {
		PROTO_NONE    = 2'd0,
		PROTO_NEC     = 2'd1,
		PROTO_SAMSUNG = 2'd2
	} proto_t;

	typedef struct packed {
		logic             first_level;
		logic [DUR_W-1:0] first_duration;
		logic             second_level;
		logic [DUR_W-1:0] second_duration;
		logic             frame_end;
	} sym_t;

	typedef struct packed {
		proto_t protocol;
		code_t  code;
		len_t   frame_length;
	} res_t;

	function automatic logic near(logic [DUR_W-1:0] d, logic [DUR_W-1:0] nom, tol_t tol);
		logic [DUR_W:0] lo;
		logic [DUR_W:0] hi;
		logic [DUR_W:0] dx;
		lo = {1'b0, nom} - {{(DUR_W+1-TOL_W){1'b0}}, tol};
		hi = {1'b0, nom} + {{(DUR_W+1-TOL_W){1'b0}}, tol};
		dx = {1'b0, d};
		return (dx >= lo) && (dx <= hi);
	endfunction

endpackage

// ===== design/nsir_if.sv =====
// Valid/ready channel interfaces for symbols, results and the tolerance write.
interface nsir_sym_if;
	logic          valid;
	logic          ready;
	nsir_pkg::sym_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nsir_res_if;
	logic          valid;
	logic          ready;
	nsir_pkg::res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nsir_cfg_if;
	logic          valid;
	logic          ready;
	nsir_pkg::tol_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/nec_samsung_ir_frame_decoder_top.sv =====
// Top level of the NEC/Samsung IR frame decoder.
//
// sym carries one captured IR symbol per request: two level/duration halves
// and a frame_end mark. NEC and Samsung framing are tracked side by side;
// the symbol with frame_end set produces one request on res with protocol,
// code and frame length, and clears the frame state. Other symbols produce
// nothing.
// cfg writes the tolerance register; it is always ready and should only be
// written while no frame is in flight.
// Throughput: one symbol per cycle unless a frame_end symbol waits on res,
// set by the single input register stage feeding the compare and shift
// logic. Results pass the input register and then the output register to res.
// Reset clears the frame state, empties both registers and loads the
// tolerance with 200.
// When res stalls, a pending result is held in the output register; further
// symbols without frame_end keep flowing, and a frame_end symbol waits in the
// input register until the output register frees up.
module nec_samsung_ir_frame_decoder_top #(
	parameter int CODE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	nsir_sym_if.sink      sym,
	nsir_cfg_if.sink      cfg,
	nsir_res_if.source    res
);

	localparam logic [nsir_pkg::LEN_W-1:0] LastBit   = nsir_pkg::LEN_W'(CODE_BITS);
	localparam logic [nsir_pkg::LEN_W-1:0] FooterIdx = nsir_pkg::LEN_W'(CODE_BITS + 1);
	localparam logic [nsir_pkg::LEN_W-1:0] MinLen    = nsir_pkg::LEN_W'(CODE_BITS + 2);

	nsir_pkg::tol_t          tol_q;
	logic                    valid_s1;
	nsir_pkg::sym_t          sym_s1;
	nsir_pkg::len_t          count_q;
	logic                    nec_alive_q;
	logic                    sam_alive_q;
	logic [CODE_BITS-1:0]    shift_q;
	logic                    res_valid_q;
	nsir_pkg::res_t          res_q;

	logic                    fire_s1;
	logic                    lvl_ok;
	logic                    nec_hdr;
	logic                    sam_hdr;
	logic                    one_ok;
	logic                    zero_ok;
	logic                    foot_ok;
	logic                    nec_nx;
	logic                    sam_nx;
	logic [CODE_BITS-1:0]    shift_nx;
	nsir_pkg::len_t          count_nx;
	nsir_pkg::proto_t        proto_nx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= nsir_pkg::TOL_RESET;
		end else if (cfg.valid) begin
			tol_q <= cfg.data;
		end
	end

	// hold a frame_end symbol while the result register is occupied and res is not ready
	assign fire_s1   = valid_s1 && (!sym_s1.frame_end || !res_valid_q || res.ready);
	assign sym.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sym.ready) begin
			valid_s1 <= sym.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sym.valid && sym.ready) begin
			sym_s1 <= sym.payload;
		end
	end

	assign lvl_ok  = !sym_s1.first_level && sym_s1.second_level;
	assign nec_hdr = lvl_ok
		&& nsir_pkg::near(sym_s1.first_duration, nsir_pkg::NEC_HDR_MARK, tol_q)
		&& nsir_pkg::near(sym_s1.second_duration, nsir_pkg::NEC_HDR_SPACE, tol_q);
	assign sam_hdr = lvl_ok
		&& nsir_pkg::near(sym_s1.first_duration, nsir_pkg::SAM_HDR_MARK, tol_q)
		&& nsir_pkg::near(sym_s1.second_duration, nsir_pkg::SAM_HDR_SPACE, tol_q);
	assign one_ok  = lvl_ok
		&& nsir_pkg::near(sym_s1.first_duration, nsir_pkg::BIT_MARK, tol_q)
		&& nsir_pkg::near(sym_s1.second_duration, nsir_pkg::ONE_SPACE, tol_q);
	assign zero_ok = lvl_ok
		&& nsir_pkg::near(sym_s1.first_duration, nsir_pkg::BIT_MARK, tol_q)
		&& nsir_pkg::near(sym_s1.second_duration, nsir_pkg::ZERO_SPACE, tol_q);
	assign foot_ok = lvl_ok
		&& nsir_pkg::near(sym_s1.first_duration, nsir_pkg::FOOTER_MARK, tol_q);

	always_comb begin
		nec_nx   = nec_alive_q;
		sam_nx   = sam_alive_q;
		shift_nx = shift_q;
		priority if (count_q == '0) begin
			nec_nx = nec_alive_q && nec_hdr;
			sam_nx = sam_alive_q && sam_hdr;
		end else if (count_q <= LastBit) begin
			shift_nx = {shift_q[CODE_BITS-2:0], one_ok};
			if (!one_ok && !zero_ok) begin
				nec_nx = 1'b0;
				sam_nx = 1'b0;
			end
		end else if (count_q == FooterIdx) begin
			if (!foot_ok) begin
				nec_nx = 1'b0;
				sam_nx = 1'b0;
			end
		end else begin
			// ignore symbols past the footer
			shift_nx = shift_q;
		end

		count_nx = (count_q == nsir_pkg::LEN_MAX) ? count_q : count_q + 1'b1;

		proto_nx = nsir_pkg::PROTO_NONE;
		if (count_nx >= MinLen && shift_nx != '0) begin
			if (nec_nx) begin
				proto_nx = nsir_pkg::PROTO_NEC;
			end else if (sam_nx) begin
				proto_nx = nsir_pkg::PROTO_SAMSUNG;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			nec_alive_q <= 1'b1;
			sam_alive_q <= 1'b1;
			shift_q     <= '0;
		end else if (fire_s1) begin
			if (sym_s1.frame_end) begin
				count_q     <= '0;
				nec_alive_q <= 1'b1;
				sam_alive_q <= 1'b1;
				shift_q     <= '0;
			end else begin
				count_q     <= count_nx;
				nec_alive_q <= nec_nx;
				sam_alive_q <= sam_nx;
				shift_q     <= shift_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && sym_s1.frame_end) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && sym_s1.frame_end) begin
			res_q.protocol     <= proto_nx;
			res_q.code         <= (proto_nx == nsir_pkg::PROTO_NONE) ? '0
				: nsir_pkg::code_t'(shift_nx);
			res_q.frame_length <= count_nx;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	a_code_iff_proto: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.protocol == nsir_pkg::PROTO_NONE) == (res_q.code == '0)))
		else $error("result code and protocol disagree");

	a_proto_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.protocol != nsir_pkg::PROTO_NONE |-> res_q.frame_length >= MinLen)
		else $error("protocol reported on a short frame");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && sym_s1.frame_end |=> count_q == '0 && nec_alive_q && sam_alive_q
			&& shift_q == '0)
		else $error("frame state not cleared after frame end");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !(fire_s1 && sym_s1.frame_end))
		else $error("pending result overwritten");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !sym_s1.frame_end && count_q != nsir_pkg::LEN_MAX
			|=> count_q == $past(count_q) + 1'b1)
		else $error("symbol count did not advance");

endmodule
